// File: rtl/otb_pkg.sv
// shared types and constants of the one-shot timer bank
package otb_pkg;

    localparam int TickW = 16;
    localparam int ConnW = 8;
    localparam int CfgIdxW = 2;

    localparam logic [TickW-1:0] TimeoutTicksRst = 16'd300;
    localparam logic [TickW-1:0] PollTicksRst = 16'd10;

    localparam logic KindTimeout = 1'b0;
    localparam logic KindPoll = 1'b1;

    typedef enum logic [2:0] {
        OP_TICK          = 3'd0,
        OP_START_TIMEOUT = 3'd1,
        OP_START_POLL    = 3'd2,
        OP_STOP_TIMEOUT  = 3'd3,
        OP_STOP_POLL     = 3'd4
    } t_opcode;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_TIMEOUT_TICKS = 2'd0,
        CFG_POLL_TICKS    = 2'd1
    } t_cfg_index;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_WALK,
        BK_FLUSH
    } t_back_state;

    // command passed from the front to the back
    typedef struct packed {
        logic             is_tick;
        logic [ConnW-1:0] idx;
        logic [TickW-1:0] ticks;
        logic             kind;
    } t_cmd;

    // one timer entry
    typedef struct packed {
        logic             kind;
        logic [TickW-1:0] ticks;
    } t_entry;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic nempty;
    } t_q_stat;

    // back status
    typedef struct packed {
        logic flushing;
        logic pend_valid;
    } t_back_stat;

endpackage

// File: rtl/per_connection_oneshot_timer_bank.sv
// top level of the per-connection one-shot timer bank
//
//  channel   direction  handshake               payload
//  in        input      i_in_valid/o_in_stall   i_opcode, i_conn_id
//  out       output     o_out_valid/i_out_stall o_expired_conn, o_expired_kind, o_last
//  cfg       input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
//  start and stop items are written to the timer memory in the back as they leave the queue
//  a tick walks the whole timer memory in the back
//  a tick with any expiry ends with a flush of the final expiry
//  a stall on the output during a walk can hold the walk
//  the front keeps taking items until the two-entry queue is full
//  synchronous reset stops all timers at once through per-entry valid bits
module per_connection_oneshot_timer_bank
    import otb_pkg::*;
#(
    parameter int CONNECTIONS = 15
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [TickW-1:0]   i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_opcode,
    input  logic [ConnW-1:0]   i_conn_id,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [ConnW-1:0]   o_expired_conn,
    output logic               o_expired_kind,
    output logic               o_last
);

    t_cmd       front_cmd;
    t_cmd       queue_cmd;
    logic       push;
    logic       pop;
    t_q_stat    q_stat;
    t_back_stat back_stat;

    otb_front #(
        .CONNECTIONS(CONNECTIONS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_opcode   (i_opcode),
        .i_conn_id  (i_conn_id),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_cmd      (front_cmd)
    );

    otb_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (front_cmd),
        .i_pop  (pop),
        .o_cmd  (queue_cmd),
        .o_stat (q_stat)
    );

    otb_back #(
        .CONNECTIONS(CONNECTIONS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (queue_cmd),
        .i_q_stat      (q_stat),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_expired_conn(o_expired_conn),
        .o_expired_kind(o_expired_kind),
        .o_last        (o_last),
        .o_stat        (back_stat)
    );

`ifndef ASSERT_OFF
    a_conn_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_expired_conn != '0) &&
                        (o_expired_conn <= ConnW'(CONNECTIONS)))
        else $error("expiry for a connection out of range");

    a_ascending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last && !i_out_stall) |=>
            (!o_out_valid || (o_expired_conn > $past(o_expired_conn))))
        else $error("expiries of one tick not in ascending order");

    a_flush_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_stat.flushing |-> back_stat.pend_valid)
        else $error("final expiry flush without a held expiry");
`endif

endmodule

// File: rtl/otb_front.sv
// front: config registers, item decode and command build
module otb_front
    import otb_pkg::*;
#(
    parameter int CONNECTIONS = 15
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [TickW-1:0]   i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_opcode,
    input  logic [ConnW-1:0]   i_conn_id,
    input  t_q_stat            i_q_stat,
    output logic               o_push,
    output t_cmd               o_cmd
);

    logic [TickW-1:0] r_timeout_ticks;
    logic [TickW-1:0] r_poll_ticks;
    logic             in_range;
    logic             keep;
    logic             accept;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ticks <= TimeoutTicksRst;
            r_poll_ticks <= PollTicksRst;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TIMEOUT_TICKS: r_timeout_ticks <= i_cfg_data;
                CFG_POLL_TICKS: r_poll_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_in_stall = i_q_stat.full;
    assign accept = i_in_valid && !i_q_stat.full;
    assign in_range = (i_conn_id != '0) && (i_conn_id <= ConnW'(CONNECTIONS));

    always_comb begin
        keep = 1'b0;
        o_cmd.is_tick = 1'b0;
        o_cmd.idx = i_conn_id - ConnW'(1);
        o_cmd.ticks = '0;
        o_cmd.kind = KindTimeout;
        unique case (i_opcode) inside
            OP_TICK: begin
                keep = 1'b1;
                o_cmd.is_tick = 1'b1;
            end
            OP_START_TIMEOUT: begin
                keep = in_range;
                o_cmd.ticks = r_timeout_ticks;
            end
            OP_START_POLL: begin
                keep = in_range;
                o_cmd.ticks = r_poll_ticks;
                o_cmd.kind = KindPoll;
            end
            OP_STOP_TIMEOUT, OP_STOP_POLL: begin
                keep = in_range;
            end
            default: ;
        endcase
    end

    assign o_push = accept && keep;

endmodule

// File: rtl/otb_queue.sv
// two-entry command queue between front and back
module otb_queue
    import otb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    input  logic    i_pop,
    output t_cmd    o_cmd,
    output t_q_stat o_stat
);

    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_stat.full = (r_count == 2'd2);
    assign o_stat.nempty = (r_count != 2'd0);
    assign do_push = i_push && !o_stat.full;
    assign do_pop = i_pop && o_stat.nempty;
    assign o_cmd = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10: r_count <= r_count + 2'd1;
                2'b01: r_count <= r_count - 2'd1;
                default: ;
            endcase
        end
    end

endmodule

// File: rtl/otb_back.sv
// back: timer memory, tick walk and expiry output
module otb_back
    import otb_pkg::*;
#(
    parameter int CONNECTIONS = 15
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  t_q_stat          i_q_stat,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [ConnW-1:0] o_expired_conn,
    output logic             o_expired_kind,
    output logic             o_last,
    output t_back_stat       o_stat
);

    localparam int AW = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
    localparam int IW = $clog2(CONNECTIONS + 1);

    t_back_state r_state;
    t_back_state n_state;

    t_entry           mem [CONNECTIONS];
    logic [CONNECTIONS-1:0] r_vld;

    logic [IW-1:0]    r_rd_idx;
    logic             r_ev_valid;
    logic [AW-1:0]    r_ev_idx;
    t_entry           r_rd_data;
    logic             r_ev_vld;

    logic             r_pend_valid;
    logic [ConnW-1:0] r_pend_conn;
    logic             r_pend_kind;

    logic             r_out_valid;
    logic [ConnW-1:0] r_out_conn;
    logic             r_out_kind;
    logic             r_out_last;

    logic             rd_more;
    logic [AW-1:0]    rd_addr;
    logic [TickW-1:0] ev_ticks;
    logic [ConnW-1:0] ev_conn;
    logic             ev_fire;
    logic             out_free;
    logic             advance;
    logic             out_push;
    logic             out_last;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    t_entry           wr_data;

    assign rd_more = (r_rd_idx < IW'(CONNECTIONS));
    assign rd_addr = r_rd_idx[AW-1:0];
    assign ev_ticks = r_ev_vld ? r_rd_data.ticks : '0;
    assign ev_conn = ConnW'(r_ev_idx) + ConnW'(1);
    assign out_free = !r_out_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_q_stat.nempty && i_cmd.is_tick) begin
                    n_state = BK_WALK;
                end
            end
            BK_WALK: begin
                if (!rd_more && !r_ev_valid) begin
                    n_state = r_pend_valid ? BK_FLUSH : BK_IDLE;
                end
            end
            BK_FLUSH: begin
                if (out_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_pop = 1'b0;
        ev_fire = 1'b0;
        out_push = 1'b0;
        out_last = 1'b0;
        wr_en = 1'b0;
        wr_addr = r_ev_idx;
        wr_data = '{kind: r_rd_data.kind, ticks: ev_ticks - TickW'(1)};
        advance = 1'b1;
        unique case (r_state)
            BK_IDLE: begin
                o_pop = i_q_stat.nempty;
                if (i_q_stat.nempty && !i_cmd.is_tick) begin
                    wr_en = 1'b1;
                    wr_addr = i_cmd.idx[AW-1:0];
                    wr_data = '{kind: i_cmd.kind, ticks: i_cmd.ticks};
                end
            end
            BK_WALK: begin
                ev_fire = r_ev_valid && (ev_ticks == TickW'(1));
                advance = !(ev_fire && r_pend_valid && !out_free);
                out_push = ev_fire && r_pend_valid && out_free;
                wr_en = r_ev_valid && (ev_ticks != '0) && advance;
            end
            BK_FLUSH: begin
                out_push = out_free;
                out_last = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // timer memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (r_state == BK_WALK && advance && rd_more) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_ev_vld <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (r_state == BK_WALK && advance && rd_more) begin
                r_ev_vld <= r_vld[rd_addr];
            end
        end
    end

    // walk control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx <= '0;
            r_ev_valid <= 1'b0;
            r_ev_idx <= '0;
        end else if (r_state == BK_IDLE) begin
            r_rd_idx <= '0;
            r_ev_valid <= 1'b0;
        end else if (r_state == BK_WALK && advance) begin
            r_ev_valid <= rd_more;
            r_ev_idx <= rd_addr;
            if (rd_more) begin
                r_rd_idx <= r_rd_idx + IW'(1);
            end
        end
    end

    // expiry held back until the next one shows whether it is the last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (r_state == BK_WALK && advance && ev_fire) begin
            r_pend_valid <= 1'b1;
        end else if (r_state == BK_FLUSH && out_free) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == BK_WALK && advance && ev_fire) begin
            r_pend_conn <= ev_conn;
            r_pend_kind <= r_rd_data.kind;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_push) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_push) begin
            r_out_conn <= r_pend_conn;
            r_out_kind <= r_pend_kind;
            r_out_last <= out_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_expired_conn = r_out_conn;
    assign o_expired_kind = r_out_kind;
    assign o_last = r_out_last;

    assign o_stat.flushing = (r_state == BK_FLUSH);
    assign o_stat.pend_valid = r_pend_valid;

endmodule

// File: tb/per_connection_oneshot_timer_bank_tb.sv
`timescale 1ns / 100ps
// testbench of the per-connection one-shot timer bank: directed and random items, self-checking
module per_connection_oneshot_timer_bank_tb;
    import otb_pkg::*;

    localparam int Conns = 15;
    localparam int DrainCycles = 3 * (Conns + 4);
    localparam int LongHold = 250;
    localparam int WatchdogLimit = 4000;
    localparam int MaxReport = 10;

    typedef struct packed {
        logic [ConnW-1:0] conn;
        logic             kind;
        logic             last;
    } t_expiry;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [CfgIdxW-1:0] i_cfg_index = '0;
    logic [TickW-1:0]   i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [2:0]         i_opcode = '0;
    logic [ConnW-1:0]   i_conn_id = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [ConnW-1:0]   o_expired_conn;
    logic               o_expired_kind;
    logic               o_last;

    // timer bank as the testbench sees it
    logic [TickW-1:0] ticks_left [1:Conns];
    logic             runs_poll [1:Conns];
    logic [TickW-1:0] cfg_timeout_ticks;
    logic [TickW-1:0] cfg_poll_ticks;
    t_expiry          due_expiries [$];

    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    int hold_cycles = 0;

    int mismatches = 0;
    int items_sent = 0;
    int ticks_sent = 0;
    int expiries_checked = 0;
    int cfg_writes = 0;
    int in_stall_cycles = 0;
    int out_hold_cycles = 0;
    int quiet_cycles = 0;

    per_connection_oneshot_timer_bank #(
        .CONNECTIONS(Conns)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_conn_id      (i_conn_id),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_expired_conn (o_expired_conn),
        .o_expired_kind (o_expired_kind),
        .o_last         (o_last)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    task automatic predict_expiries(input logic [2:0] op, input logic [ConnW-1:0] conn);
        t_expiry fired [$];
        bit      in_range;
        in_range = (conn >= 1) && (conn <= Conns);
        case (op) inside
            OP_START_TIMEOUT: begin
                if (in_range) begin
                    ticks_left[conn] = cfg_timeout_ticks;
                    runs_poll[conn] = KindTimeout;
                end
            end
            OP_START_POLL: begin
                if (in_range) begin
                    ticks_left[conn] = cfg_poll_ticks;
                    runs_poll[conn] = KindPoll;
                end
            end
            OP_STOP_TIMEOUT, OP_STOP_POLL: begin
                if (in_range) begin
                    ticks_left[conn] = '0;
                    runs_poll[conn] = KindTimeout;
                end
            end
            OP_TICK: begin
                ticks_sent++;
                for (int c = 1; c <= Conns; c++) begin
                    if (ticks_left[c] != 0) begin
                        ticks_left[c] = ticks_left[c] - 1'b1;
                        if (ticks_left[c] == 0)
                            fired.push_back('{conn: ConnW'(c), kind: runs_poll[c], last: 1'b0});
                    end
                end
                if (fired.size() > 0)
                    fired[fired.size() - 1].last = 1'b1;
                foreach (fired[k])
                    due_expiries.push_back(fired[k]);
            end
            default: ;
        endcase
    endtask

    task automatic send_item(input logic [2:0] op, input logic [ConnW-1:0] conn);
        int gap;
        gap = tx_idle ? $urandom_range(0, 12) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode <= op;
        i_conn_id <= conn;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        predict_expiries(op, conn);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (due_expiries.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [TickW-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_TIMEOUT_TICKS)
            cfg_timeout_ticks = data;
        else if (idx == CFG_POLL_TICKS)
            cfg_poll_ticks = data;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [TickW-1:0] timeout_ticks,
                              input logic [TickW-1:0] poll_ticks);
        drain();
        write_reg(CFG_TIMEOUT_TICKS, timeout_ticks);
        write_reg(CFG_POLL_TICKS, poll_ticks);
    endtask

    function automatic logic [ConnW-1:0] rand_conn();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r == 1)
            return ConnW'($urandom_range(Conns + 1, (1 << ConnW) - 1));
        return ConnW'($urandom_range(1, Conns));
    endfunction

    task automatic test_reset_values();
        send_item(OP_START_TIMEOUT, 8'd1);
        send_item(OP_START_POLL, ConnW'(Conns));
        repeat (PollTicksRst) send_item(OP_TICK, 8'd0);
        // stop of the other kind still clears the timeout timer
        send_item(OP_STOP_POLL, 8'd1);
        drain();
    endtask

    task automatic test_commands();
        set_config(16'd2, 16'd1);
        send_item(OP_START_TIMEOUT, 8'd0);
        send_item(OP_START_TIMEOUT, ConnW'(Conns + 1));
        send_item(OP_START_POLL, 8'hFF);
        send_item(OP_START_TIMEOUT, 8'd1);
        send_item(OP_START_TIMEOUT, ConnW'(Conns));
        send_item(OP_START_POLL, 8'd7);
        send_item(OP_START_POLL, 8'd3);
        for (int k = int'(OP_STOP_POLL) + 1; k < (1 << 3); k++)
            send_item(3'(k), 8'd7);
        send_item(OP_STOP_TIMEOUT, 8'd3);
        send_item(OP_TICK, 8'hAA);
        send_item(OP_TICK, 8'h55);
        send_item(OP_TICK, 8'd0);
        // zero ticks configured leaves the timer stopped
        set_config(16'd0, 16'hFFFF);
        send_item(OP_START_TIMEOUT, 8'd4);
        send_item(OP_START_POLL, 8'd5);
        send_item(OP_TICK, 8'hFF);
        send_item(OP_STOP_POLL, 8'd5);
        send_item(OP_TICK, 8'd0);
        drain();
    endtask

    task automatic test_backpressure();
        set_config(16'd1, 16'd1);
        hold_cycles = LongHold;
        tx_idle = 1'b0;
        repeat (3) begin
            for (int c = 1; c <= Conns; c++)
                send_item((c % 2) ? OP_START_POLL : OP_START_TIMEOUT, ConnW'(c));
            send_item(OP_TICK, 8'd0);
        end
        tx_idle = 1'b1;
        drain();
    endtask

    task automatic test_random();
        logic [TickW-1:0] timeout_tab [5];
        logic [TickW-1:0] poll_tab [5];
        logic [2:0]       op;
        logic [ConnW-1:0] conn;
        int               r;
        timeout_tab = '{16'd3, 16'd1, 16'hFFFF, 16'd0, 16'd12};
        poll_tab = '{16'd5, 16'd1, 16'd2, 16'd4, 16'hFFFF};
        for (int phase = 0; phase < 5; phase++) begin
            set_config(timeout_tab[phase], poll_tab[phase]);
            // index beyond the register list
            write_reg(CfgIdxW'(int'(CFG_POLL_TICKS) + 1 + $urandom_range(0, 1)),
                      TickW'($urandom));
            for (int i = 0; i < 18; i++) begin
                if (i % 12 == 0) begin
                    tx_idle = ($urandom_range(0, 3) != 0);
                    rx_idle = ($urandom_range(0, 3) != 0);
                end
                r = $urandom_range(0, 99);
                conn = rand_conn();
                if (r < 38) begin
                    op = OP_TICK;
                    conn = ConnW'($urandom_range(0, (1 << ConnW) - 1));
                end else if (r < 60) begin
                    op = OP_START_TIMEOUT;
                end else if (r < 82) begin
                    op = OP_START_POLL;
                end else if (r < 88) begin
                    op = OP_STOP_TIMEOUT;
                end else if (r < 94) begin
                    op = OP_STOP_POLL;
                end else begin
                    op = 3'($urandom_range(int'(OP_STOP_POLL) + 1, (1 << 3) - 1));
                    conn = ConnW'($urandom_range(0, (1 << ConnW) - 1));
                end
                send_item(op, conn);
            end
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        drain();
    endtask

    initial begin : receiver
        int n;
        forever begin
            if (hold_cycles > 0) begin
                n = hold_cycles;
                hold_cycles = 0;
            end else begin
                n = rx_idle ? $urandom_range(0, 12) : 0;
            end
            if (n > 0) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
                repeat (n - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_out_stall <= 1'b0;
            do @(posedge i_clk);
            while (!(o_out_valid && !i_out_stall) && hold_cycles == 0);
        end
    end

    always @(posedge i_clk) begin : expiry_check
        t_expiry want;
        t_expiry got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{conn: o_expired_conn, kind: o_expired_kind, last: o_last};
            if (due_expiries.size() == 0) begin
                mismatches++;
                if (mismatches <= MaxReport)
                    $display("unexpected expiry: conn %0d kind %0d last %0d",
                             got.conn, got.kind, got.last);
            end else begin
                want = due_expiries.pop_front();
                expiries_checked++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MaxReport)
                        $display("expiry mismatch: expected conn %0d kind %0d last %0d,",
                                 want.conn, want.kind, want.last,
                                 " got conn %0d kind %0d last %0d",
                                 got.conn, got.kind, got.last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_in_valid && o_in_stall)
            in_stall_cycles++;
        if (i_out_stall)
            out_hold_cycles++;
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WatchdogLimit) begin
            $display("watchdog: no handshake for %0d cycles, %0d expiries outstanding",
                     WatchdogLimit, due_expiries.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        for (int c = 1; c <= Conns; c++) begin
            ticks_left[c] = '0;
            runs_poll[c] = KindTimeout;
        end
        cfg_timeout_ticks = TimeoutTicksRst;
        cfg_poll_ticks = PollTicksRst;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_commands();
        test_backpressure();
        test_random();
        drain();

        if (due_expiries.size() != 0) begin
            mismatches += due_expiries.size();
            $display("%0d expected expiries never arrived", due_expiries.size());
        end
        $display("sent %0d items (%0d ticks) over %0d register writes, checked %0d expiries",
                 items_sent, ticks_sent, cfg_writes, expiries_checked);
        $display("input stalled %0d cycles, output held off %0d cycles, %0d mismatches",
                 in_stall_cycles, out_hold_cycles, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
